// File: hdl/bounded_doubly_linked_list_assert.svh
// assertion macros shared by the list engine modules
// expects clk_i and rst_ni in the scope of every use
`ifndef BOUNDED_DOUBLY_LINKED_LIST_ASSERT_SVH
`define BOUNDED_DOUBLY_LINKED_LIST_ASSERT_SVH

// same-cycle implication
`define BDLL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BDLL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/bdll_pkg.sv
// shared types, codes and defaults of the linked list engine
// no dependencies
`timescale 1ns / 1ps

package bdll_pkg;

  localparam int unsigned DEPTH_DEFAULT       = 256;
  localparam int unsigned VALUE_WIDTH_DEFAULT = 32;

  typedef enum logic [3:0] {
    K_INS_HEAD = 4'd0,
    K_INS_TAIL = 4'd1,
    K_INS_POS  = 4'd2,
    K_DEL_HEAD = 4'd3,
    K_DEL_TAIL = 4'd4,
    K_DEL_POS  = 4'd5,
    K_DEL_VAL  = 4'd6,
    K_REVERSE  = 4'd7,
    K_FIND     = 4'd8,
    K_LENGTH   = 4'd9
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_BOUNDS    = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    END_EMPTY,
    END_HEAD,
    END_TAIL,
    END_MID
  } ins_end_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_POP,
    S_READ,
    S_WALK,
    S_LINK
  } state_e;

  typedef struct packed {
    logic [3:0]         kind;
    logic [7:0]         position;
    logic signed [31:0] item_value;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] removed_value;
    logic [8:0]         index_or_length;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic     load;
    logic     take;
    ins_end_e ins_end;
    logic     start_head;
    logic     start_tail;
    logic     advance;
    logic     unlink;
    logic     link_a;
    logic     link_b;
    logic     swap;
    logic     swap_ends;
    logic     put_index;
    logic     put_length;
    logic     finish;
    status_e  status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [3:0] kind;
    logic       empty;
    logic       multi;
    logic       full;
    logic       pos_above;
    logic       pos_ge;
    logic       pos_zero;
    logic       pos_at_len;
    logic       at_pos;
    logic       last;
    logic       match;
  } stat_t;

endpackage

// File: hdl/bounded_doubly_linked_list.sv
// Doubly linked list engine, one request at a time, one result strobe per request.
// Inserts at an end finish once a node is taken from the free stack; deletes, finds and
// reverse walk the list from the head (the tail for delete at the tail), one node per read
// and walk state; insert inside the list walks to position p and then links the new node.
// Length and rejected requests finish in the check state.
// Each walk step is a registered read of the node stores; the next request is taken
// in the cycle done_o shows. The receiver cannot stall. Async reset empties the list.
`timescale 1ns / 1ps

module bounded_doubly_linked_list #(
  parameter int unsigned DEPTH       = bdll_pkg::DEPTH_DEFAULT,
  parameter int unsigned VALUE_WIDTH = bdll_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  bdll_pkg::req_t req_i,
  output logic           busy,
  output logic           done_o,
  output bdll_pkg::rsp_t rsp_o
);

  bdll_pkg::cmd_t  cmd;
  bdll_pkg::stat_t stat;

  bdll_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  bdll_dp #(
    .DEPTH      (DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_i),
    .cmd_i (cmd),
    .stat_o(stat),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

endmodule

// File: hdl/bdll_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module bdll_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/bdll_ctrl.sv
// operation sequencer of the linked list engine
// depends on bdll_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "bounded_doubly_linked_list_assert.svh"

module bdll_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  bdll_pkg::stat_t stat_i,
  output bdll_pkg::cmd_t  cmd_o,
  output logic           busy_o
);

  bdll_pkg::state_e   state_q, state_d;
  bdll_pkg::kind_e    kind;
  bdll_pkg::ins_end_e ins_end;

  assign kind = bdll_pkg::kind_e'(stat_i.kind);

  // where a freshly taken node goes
  always_comb begin
    priority if (stat_i.empty) begin
      ins_end = bdll_pkg::END_EMPTY;
    end else if (kind == bdll_pkg::K_INS_HEAD) begin
      ins_end = bdll_pkg::END_HEAD;
    end else if (kind == bdll_pkg::K_INS_TAIL) begin
      ins_end = bdll_pkg::END_TAIL;
    end else if (stat_i.pos_zero) begin
      ins_end = bdll_pkg::END_HEAD;
    end else if (stat_i.pos_at_len) begin
      ins_end = bdll_pkg::END_TAIL;
    end else begin
      ins_end = bdll_pkg::END_MID;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bdll_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bdll_pkg::S_IDLE: begin
        if (start_i) state_d = bdll_pkg::S_CHECK;
      end
      bdll_pkg::S_CHECK: begin
        unique case (kind)
          bdll_pkg::K_INS_HEAD, bdll_pkg::K_INS_TAIL, bdll_pkg::K_INS_POS: begin
            if ((kind == bdll_pkg::K_INS_POS && stat_i.pos_above) || stat_i.full) begin
              state_d = bdll_pkg::S_IDLE;
            end else begin
              state_d = bdll_pkg::S_POP;
            end
          end
          bdll_pkg::K_DEL_HEAD, bdll_pkg::K_DEL_TAIL, bdll_pkg::K_DEL_POS,
          bdll_pkg::K_DEL_VAL, bdll_pkg::K_FIND: begin
            if (stat_i.empty || (kind == bdll_pkg::K_DEL_POS && stat_i.pos_ge)) begin
              state_d = bdll_pkg::S_IDLE;
            end else begin
              state_d = bdll_pkg::S_READ;
            end
          end
          bdll_pkg::K_REVERSE: begin
            state_d = stat_i.multi ? bdll_pkg::S_READ : bdll_pkg::S_IDLE;
          end
          default: state_d = bdll_pkg::S_IDLE;
        endcase
      end
      bdll_pkg::S_POP: begin
        state_d = (ins_end == bdll_pkg::END_MID) ? bdll_pkg::S_READ : bdll_pkg::S_IDLE;
      end
      bdll_pkg::S_READ: state_d = bdll_pkg::S_WALK;
      bdll_pkg::S_WALK: begin
        unique case (kind)
          bdll_pkg::K_DEL_POS: begin
            state_d = stat_i.at_pos ? bdll_pkg::S_IDLE : bdll_pkg::S_READ;
          end
          bdll_pkg::K_INS_POS: begin
            state_d = stat_i.at_pos ? bdll_pkg::S_LINK : bdll_pkg::S_READ;
          end
          bdll_pkg::K_DEL_VAL, bdll_pkg::K_FIND: begin
            if (stat_i.match || stat_i.last) begin
              state_d = bdll_pkg::S_IDLE;
            end else begin
              state_d = bdll_pkg::S_READ;
            end
          end
          bdll_pkg::K_REVERSE: begin
            state_d = stat_i.last ? bdll_pkg::S_IDLE : bdll_pkg::S_READ;
          end
          default: state_d = bdll_pkg::S_IDLE;
        endcase
      end
      bdll_pkg::S_LINK: state_d = bdll_pkg::S_IDLE;
      default: state_d = bdll_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      bdll_pkg::S_IDLE: begin
        cmd_o.load = start_i;
      end
      bdll_pkg::S_CHECK: begin
        unique case (kind)
          bdll_pkg::K_INS_HEAD, bdll_pkg::K_INS_TAIL, bdll_pkg::K_INS_POS: begin
            if (kind == bdll_pkg::K_INS_POS && stat_i.pos_above) begin
              cmd_o.finish = 1'b1;
              cmd_o.status = bdll_pkg::ST_BOUNDS;
            end else if (stat_i.full) begin
              cmd_o.finish = 1'b1;
              cmd_o.status = bdll_pkg::ST_FULL;
            end
          end
          bdll_pkg::K_DEL_HEAD, bdll_pkg::K_DEL_TAIL, bdll_pkg::K_DEL_POS,
          bdll_pkg::K_DEL_VAL: begin
            if (stat_i.empty) begin
              cmd_o.finish = 1'b1;
              cmd_o.status = bdll_pkg::ST_EMPTY;
            end else if (kind == bdll_pkg::K_DEL_POS && stat_i.pos_ge) begin
              cmd_o.finish = 1'b1;
              cmd_o.status = bdll_pkg::ST_BOUNDS;
            end else if (kind == bdll_pkg::K_DEL_TAIL) begin
              cmd_o.start_tail = 1'b1;
            end else begin
              cmd_o.start_head = 1'b1;
            end
          end
          bdll_pkg::K_FIND: begin
            if (stat_i.empty) begin
              cmd_o.finish = 1'b1;
              cmd_o.status = bdll_pkg::ST_NOT_FOUND;
            end else begin
              cmd_o.start_head = 1'b1;
            end
          end
          bdll_pkg::K_REVERSE: begin
            if (stat_i.multi) begin
              cmd_o.start_head = 1'b1;
            end else begin
              cmd_o.finish = 1'b1;
            end
          end
          bdll_pkg::K_LENGTH: begin
            cmd_o.put_length = 1'b1;
            cmd_o.finish     = 1'b1;
          end
          default: cmd_o.finish = 1'b1;
        endcase
      end
      bdll_pkg::S_POP: begin
        cmd_o.take    = 1'b1;
        cmd_o.ins_end = ins_end;
        if (ins_end == bdll_pkg::END_MID) begin
          cmd_o.start_head = 1'b1;
        end else begin
          cmd_o.finish = 1'b1;
        end
      end
      bdll_pkg::S_READ: begin
        cmd_o = '0;
      end
      bdll_pkg::S_WALK: begin
        unique case (kind)
          bdll_pkg::K_DEL_HEAD, bdll_pkg::K_DEL_TAIL: begin
            cmd_o.unlink = 1'b1;
            cmd_o.finish = 1'b1;
          end
          bdll_pkg::K_DEL_POS: begin
            if (stat_i.at_pos) begin
              cmd_o.unlink = 1'b1;
              cmd_o.finish = 1'b1;
            end else begin
              cmd_o.advance = 1'b1;
            end
          end
          bdll_pkg::K_INS_POS: begin
            if (stat_i.at_pos) begin
              cmd_o.link_a = 1'b1;
            end else begin
              cmd_o.advance = 1'b1;
            end
          end
          bdll_pkg::K_DEL_VAL, bdll_pkg::K_FIND: begin
            if (stat_i.match) begin
              cmd_o.unlink    = (kind == bdll_pkg::K_DEL_VAL);
              cmd_o.put_index = (kind == bdll_pkg::K_FIND);
              cmd_o.finish    = 1'b1;
            end else if (stat_i.last) begin
              cmd_o.finish = 1'b1;
              cmd_o.status = bdll_pkg::ST_NOT_FOUND;
            end else begin
              cmd_o.advance = 1'b1;
            end
          end
          bdll_pkg::K_REVERSE: begin
            cmd_o.swap = 1'b1;
            if (stat_i.last) begin
              cmd_o.swap_ends = 1'b1;
              cmd_o.finish    = 1'b1;
            end else begin
              cmd_o.advance = 1'b1;
            end
          end
          default: cmd_o.finish = 1'b1;
        endcase
      end
      bdll_pkg::S_LINK: begin
        cmd_o.link_b = 1'b1;
        cmd_o.finish = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

  assign busy_o = (state_q != bdll_pkg::S_IDLE);

  `BDLL_ASSERT_NOW(a_take_not_full, cmd_o.take, !stat_i.full, "node taken from a full list")
  `BDLL_ASSERT_NOW(a_unlink_not_empty, cmd_o.unlink, !stat_i.empty, "unlink on an empty list")
  `BDLL_ASSERT_NEXT(a_load_then_check, cmd_o.load, state_q == bdll_pkg::S_CHECK, "request lost")

endmodule

// File: hdl/bdll_dp.sv
// datapath of the linked list engine: node stores, free stack, list registers
// depends on bdll_pkg, bdll_ram and the assertion macro header
`timescale 1ns / 1ps
`include "bounded_doubly_linked_list_assert.svh"

module bdll_dp #(
  parameter int unsigned DEPTH       = bdll_pkg::DEPTH_DEFAULT,
  parameter int unsigned VALUE_WIDTH = bdll_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bdll_pkg::req_t  req_i,
  input  bdll_pkg::cmd_t  cmd_i,
  output bdll_pkg::stat_t stat_o,
  output logic            done_o,
  output bdll_pkg::rsp_t  rsp_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned VW = VALUE_WIDTH;

  // list registers
  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] count_q, count_d, ftop_q, ftop_d;
  // free stack entries below this mark were never written and hold their own address
  logic [CW-1:0] low_q, low_d;
  logic          done_q, done_d;

  // request and walk registers
  logic [3:0]        kind_q, kind_d;
  logic [7:0]        pos_q, pos_d;
  logic [VW-1:0]     val_q, val_d;
  logic [AW-1:0]     cur_q, cur_d, idx_q, idx_d, node_q, node_d, before_q, before_d;
  bdll_pkg::status_e status_q, status_d;
  logic [31:0]       removed_q, removed_d;
  logic [8:0]        index_q, index_d;

  // ram ports
  logic          val_we, next_we, prev_we, free_we;
  logic [AW-1:0] val_waddr, next_waddr, prev_waddr, free_waddr;
  logic [VW-1:0] val_wdata, rd_val;
  logic [AW-1:0] next_wdata, prev_wdata, free_wdata;
  logic [AW-1:0] rd_next, rd_prev, rd_free;

  logic [CW-1:0] ftop_dec;
  logic [AW-1:0] new_node;
  logic [63:0]   item_ext, val_ext;
  logic          middle;

  assign ftop_dec = ftop_q - CW'(1);
  assign new_node = (ftop_dec < low_q) ? ftop_dec[AW-1:0] : rd_free;
  assign item_ext = 64'($unsigned(req_i.item_value));
  assign val_ext  = 64'($signed(rd_val));
  assign middle   = (count_q > CW'(1)) && (cur_q != head_q) && (cur_q != tail_q);

  bdll_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_val_ram (
    .clk_i  (clk_i),
    .we_i   (val_we),
    .waddr_i(val_waddr),
    .wdata_i(val_wdata),
    .raddr_i(cur_q),
    .rdata_o(rd_val)
  );

  bdll_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_next_ram (
    .clk_i  (clk_i),
    .we_i   (next_we),
    .waddr_i(next_waddr),
    .wdata_i(next_wdata),
    .raddr_i(cur_q),
    .rdata_o(rd_next)
  );

  bdll_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_prev_ram (
    .clk_i  (clk_i),
    .we_i   (prev_we),
    .waddr_i(prev_waddr),
    .wdata_i(prev_wdata),
    .raddr_i(cur_q),
    .rdata_o(rd_prev)
  );

  bdll_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_free_ram (
    .clk_i  (clk_i),
    .we_i   (free_we),
    .waddr_i(free_waddr),
    .wdata_i(free_wdata),
    .raddr_i(ftop_dec[AW-1:0]),
    .rdata_o(rd_free)
  );

  // memory writes, at most one per store per cycle
  always_comb begin
    val_we     = 1'b0;
    val_waddr  = new_node;
    val_wdata  = val_q;
    next_we    = 1'b0;
    next_waddr = '0;
    next_wdata = '0;
    prev_we    = 1'b0;
    prev_waddr = '0;
    prev_wdata = '0;
    free_we    = 1'b0;
    free_waddr = ftop_q[AW-1:0];
    free_wdata = cur_q;
    if (cmd_i.take) begin
      val_we = 1'b1;
      if (cmd_i.ins_end == bdll_pkg::END_HEAD) begin
        next_we    = 1'b1;
        next_waddr = new_node;
        next_wdata = head_q;
        prev_we    = 1'b1;
        prev_waddr = head_q;
        prev_wdata = new_node;
      end else if (cmd_i.ins_end == bdll_pkg::END_TAIL) begin
        prev_we    = 1'b1;
        prev_waddr = new_node;
        prev_wdata = tail_q;
        next_we    = 1'b1;
        next_waddr = tail_q;
        next_wdata = new_node;
      end
    end else if (cmd_i.link_a) begin
      next_we    = 1'b1;
      next_waddr = node_q;
      next_wdata = cur_q;
      prev_we    = 1'b1;
      prev_waddr = cur_q;
      prev_wdata = node_q;
    end else if (cmd_i.link_b) begin
      prev_we    = 1'b1;
      prev_waddr = node_q;
      prev_wdata = before_q;
      next_we    = 1'b1;
      next_waddr = before_q;
      next_wdata = node_q;
    end else if (cmd_i.unlink) begin
      free_we = (ftop_q < CW'(DEPTH));
      if (middle) begin
        next_we    = 1'b1;
        next_waddr = rd_prev;
        next_wdata = rd_next;
        prev_we    = 1'b1;
        prev_waddr = rd_next;
        prev_wdata = rd_prev;
      end
    end else if (cmd_i.swap) begin
      next_we    = 1'b1;
      next_waddr = cur_q;
      next_wdata = rd_prev;
      prev_we    = 1'b1;
      prev_waddr = cur_q;
      prev_wdata = rd_next;
    end
  end

  // register updates
  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    ftop_d   = ftop_q;
    low_d    = low_q;
    done_d   = 1'b0;
    kind_d   = kind_q;
    pos_d    = pos_q;
    val_d    = val_q;
    cur_d    = cur_q;
    idx_d    = idx_q;
    node_d   = node_q;
    before_d = before_q;
    status_d = status_q;
    removed_d = removed_q;
    index_d  = index_q;
    if (cmd_i.load) begin
      kind_d    = req_i.kind;
      pos_d     = req_i.position;
      val_d     = item_ext[VW-1:0];
      status_d  = bdll_pkg::ST_OK;
      removed_d = '0;
      index_d   = '0;
    end
    if (cmd_i.take) begin
      ftop_d = ftop_dec;
      low_d  = (ftop_dec < low_q) ? ftop_dec : low_q;
      node_d = new_node;
      unique case (cmd_i.ins_end)
        bdll_pkg::END_EMPTY: begin
          head_d  = new_node;
          tail_d  = new_node;
          count_d = count_q + CW'(1);
        end
        bdll_pkg::END_HEAD: begin
          head_d  = new_node;
          count_d = count_q + CW'(1);
        end
        bdll_pkg::END_TAIL: begin
          tail_d  = new_node;
          count_d = count_q + CW'(1);
        end
        default: count_d = count_q;
      endcase
    end
    if (cmd_i.start_head) begin
      cur_d = head_q;
      idx_d = '0;
    end
    if (cmd_i.start_tail) begin
      cur_d = tail_q;
      idx_d = '0;
    end
    if (cmd_i.advance) begin
      cur_d = rd_next;
      idx_d = idx_q + AW'(1);
    end
    if (cmd_i.unlink) begin
      if (count_q > CW'(1)) begin
        if (cur_q == head_q) begin
          head_d = rd_next;
        end else if (cur_q == tail_q) begin
          tail_d = rd_prev;
        end
      end
      if (ftop_q < CW'(DEPTH)) ftop_d = ftop_q + CW'(1);
      count_d   = count_q - CW'(1);
      removed_d = val_ext[31:0];
    end
    if (cmd_i.link_a) before_d = rd_prev;
    if (cmd_i.link_b) count_d = count_q + CW'(1);
    if (cmd_i.swap_ends) begin
      head_d = tail_q;
      tail_d = head_q;
    end
    if (cmd_i.put_index) index_d = 9'(idx_q);
    if (cmd_i.put_length) index_d = 9'(count_q);
    if (cmd_i.finish) begin
      done_d   = 1'b1;
      status_d = cmd_i.status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      ftop_q  <= CW'(DEPTH);
      low_q   <= CW'(DEPTH);
      done_q  <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      ftop_q  <= ftop_d;
      low_q   <= low_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    pos_q     <= pos_d;
    val_q     <= val_d;
    cur_q     <= cur_d;
    idx_q     <= idx_d;
    node_q    <= node_d;
    before_q  <= before_d;
    status_q  <= status_d;
    removed_q <= removed_d;
    index_q   <= index_d;
  end

  always_comb begin
    stat_o.kind       = kind_q;
    stat_o.empty      = (count_q == '0);
    stat_o.multi      = (count_q > CW'(1));
    stat_o.full       = (count_q >= CW'(DEPTH)) || (ftop_q == '0);
    stat_o.pos_above  = (32'(pos_q) > 32'(count_q));
    stat_o.pos_ge     = (32'(pos_q) >= 32'(count_q));
    stat_o.pos_zero   = (pos_q == '0);
    stat_o.pos_at_len = (32'(pos_q) == 32'(count_q));
    stat_o.at_pos     = (32'(idx_q) == 32'(pos_q));
    stat_o.last       = ((CW'(idx_q) + CW'(1)) == count_q);
    stat_o.match      = (rd_val == val_q);
  end

  assign done_o                = done_q;
  assign rsp_o.status          = status_q;
  assign rsp_o.removed_value   = removed_q;
  assign rsp_o.index_or_length = index_q;

  `BDLL_ASSERT_NOW(a_count_in_range, 1'b1, count_q <= CW'(DEPTH), "element count above depth")
  `BDLL_ASSERT_NOW(a_free_mark, 1'b1, low_q <= ftop_q, "free stack mark above free top")
  `BDLL_ASSERT_NOW(a_nodes_kept, done_q, (32'(ftop_q) + 32'(count_q)) == 32'(DEPTH), "node leaked")

endmodule

// File: dv/testbench.sv
// self-checking testbench of the bounded doubly linked list engine
// depends on bdll_pkg and bounded_doubly_linked_list; keeps its own copy of the list
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned LIST_DEPTH = 256;
  localparam int unsigned MAX_CYCLES = 5000000;

  logic   clk_i;
  logic   rst_ni;
  logic   start;
  bdll_pkg::req_t req_i;
  logic   busy;
  logic   done_o;
  bdll_pkg::rsp_t rsp_o;

  bounded_doubly_linked_list i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .req_i (req_i),
    .busy  (busy),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // predictor state: list contents in order, head first
  logic signed [31:0] list_q[$];
  bdll_pkg::req_t pending_q[$];
  bdll_pkg::rsp_t expected_q[$];
  int     sender_idle_pct;
  int     mismatches = 0;
  int     cycle_count = 0;

  function automatic bdll_pkg::rsp_t predict_list_op(bdll_pkg::req_t r);
    bdll_pkg::rsp_t res;
    int     len;
    int     hit;
    logic signed [31:0] tmp[$];
    res = '0;
    res.status = bdll_pkg::ST_OK;
    len = list_q.size();
    hit = -1;
    case (r.kind)
      bdll_pkg::K_INS_HEAD, bdll_pkg::K_INS_TAIL, bdll_pkg::K_INS_POS: begin
        if (r.kind == bdll_pkg::K_INS_POS && r.position > len) res.status = bdll_pkg::ST_BOUNDS;
        else if (len >= LIST_DEPTH) res.status = bdll_pkg::ST_FULL;
        else if (r.kind == bdll_pkg::K_INS_HEAD) list_q.push_front(r.item_value);
        else if (r.kind == bdll_pkg::K_INS_TAIL) list_q.push_back(r.item_value);
        else list_q.insert(r.position, r.item_value);
      end
      bdll_pkg::K_DEL_HEAD, bdll_pkg::K_DEL_TAIL, bdll_pkg::K_DEL_POS: begin
        if (len == 0) res.status = bdll_pkg::ST_EMPTY;
        else if (r.kind == bdll_pkg::K_DEL_POS && r.position >= len)
          res.status = bdll_pkg::ST_BOUNDS;
        else if (r.kind == bdll_pkg::K_DEL_HEAD) res.removed_value = list_q.pop_front();
        else if (r.kind == bdll_pkg::K_DEL_TAIL) res.removed_value = list_q.pop_back();
        else begin
          res.removed_value = list_q[r.position];
          list_q.delete(r.position);
        end
      end
      bdll_pkg::K_DEL_VAL, bdll_pkg::K_FIND: begin
        if (r.kind == bdll_pkg::K_DEL_VAL && len == 0) res.status = bdll_pkg::ST_EMPTY;
        else begin
          for (int i = 0; i < len; i++)
            if (hit < 0 && list_q[i] == r.item_value) hit = i;
          if (hit < 0) res.status = bdll_pkg::ST_NOT_FOUND;
          else if (r.kind == bdll_pkg::K_FIND) res.index_or_length = 9'(hit);
          else begin
            res.removed_value = list_q[hit];
            list_q.delete(hit);
          end
        end
      end
      bdll_pkg::K_REVERSE: begin
        tmp = {};
        foreach (list_q[i]) tmp.push_front(list_q[i]);
        list_q = tmp;
      end
      bdll_pkg::K_LENGTH: res.index_or_length = 9'(len);
      default: ;
    endcase
    return res;
  endfunction

  // request driver: inputs change only at rising edges or when reset is asserted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      req_i <= '0;
    end else if (start && !busy) begin
      // current request taken at this edge
      if (pending_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        req_i <= pending_q.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end else if (!start && pending_q.size() > 0 &&
                 $urandom_range(99) >= sender_idle_pct) begin
      req_i <= pending_q.pop_front();
      start <= 1'b1;
    end
  end

  // predict on acceptance, check on strobe
  always @(posedge clk_i) begin
    bdll_pkg::rsp_t exp_rsp;
    if (rst_ni) begin
      cycle_count <= cycle_count + 1;
      if (done_o) begin
        if (expected_q.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) $display("unexpected result %p", rsp_o);
        end else begin
          exp_rsp = expected_q.pop_front();
          if (rsp_o.status !== exp_rsp.status ||
              rsp_o.removed_value !== exp_rsp.removed_value ||
              rsp_o.index_or_length !== exp_rsp.index_or_length) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("mismatch: expected st=%0d rm=%0d idx=%0d got st=%0d rm=%0d idx=%0d",
                       exp_rsp.status, exp_rsp.removed_value, exp_rsp.index_or_length,
                       rsp_o.status, rsp_o.removed_value, rsp_o.index_or_length);
          end
        end
      end
      if (start && !busy) expected_q.push_back(predict_list_op(req_i));
    end
  end

  always @(posedge clk_i) begin
    if (cycle_count >= MAX_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // small value pool so finds and deletes by value hit often
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(3))
      0: return $urandom();
      1: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff};
      default: return $signed($urandom_range(15)) - 8;
    endcase
  endfunction

  task automatic queue_req(bdll_pkg::kind_e k, int p, logic signed [31:0] v);
    bdll_pkg::req_t r;
    r.kind = k;
    r.position = p[7:0];
    r.item_value = v;
    pending_q.push_back(r);
  endtask

  task automatic queue_raw(logic [3:0] k, logic [7:0] p, logic signed [31:0] v);
    bdll_pkg::req_t r;
    r.kind = k;
    r.position = p;
    r.item_value = v;
    pending_q.push_back(r);
  endtask

  task automatic wait_drained();
    while (pending_q.size() > 0 || start || expected_q.size() > 0) @(posedge clk_i);
  endtask

  // random phase: fill bias keeps the list wandering through empty, mid and full
  task automatic queue_random(int n, int fill_bias);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 2) queue_raw(4'($urandom_range(15, 10)), 8'($urandom()), $urandom());
      else if (r < fill_bias)
        queue_req(bdll_pkg::kind_e'($urandom_range(2)), $urandom_range(40), pick_value());
      else if (r < fill_bias + 25)
        queue_req(bdll_pkg::kind_e'($urandom_range(6, 3)), $urandom_range(40), pick_value());
      else if (r < 95) queue_req(bdll_pkg::K_FIND, $urandom(), pick_value());
      else queue_req(bdll_pkg::kind_e'($urandom_range(9, 7)), $urandom(), pick_value());
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    sender_idle_pct = 26;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty-list cases, bounds, extremes, unused kinds, reverse
    queue_req(bdll_pkg::K_DEL_HEAD, 0, 0);
    queue_req(bdll_pkg::K_DEL_VAL, 0, 5);
    queue_req(bdll_pkg::K_FIND, 0, 5);
    queue_req(bdll_pkg::K_REVERSE, 0, 0);
    queue_req(bdll_pkg::K_INS_POS, 1, 1);
    queue_req(bdll_pkg::K_INS_POS, 0, 32'sh7fff_ffff);
    queue_req(bdll_pkg::K_REVERSE, 0, 0);
    queue_req(bdll_pkg::K_INS_HEAD, 0, 32'sh8000_0000);
    queue_req(bdll_pkg::K_INS_TAIL, 0, -1);
    queue_req(bdll_pkg::K_INS_POS, 3, 7);
    queue_req(bdll_pkg::K_INS_POS, 2, 9);
    queue_req(bdll_pkg::K_INS_POS, 255, 0);
    queue_req(bdll_pkg::K_REVERSE, 0, 0);
    queue_req(bdll_pkg::K_FIND, 0, 7);
    queue_req(bdll_pkg::K_FIND, 0, 123);
    queue_req(bdll_pkg::K_DEL_POS, 5, 0);
    queue_req(bdll_pkg::K_DEL_POS, 255, 0);
    queue_req(bdll_pkg::K_DEL_POS, 2, 0);
    queue_req(bdll_pkg::K_DEL_VAL, 0, 77);
    queue_req(bdll_pkg::K_DEL_VAL, 0, -1);
    queue_req(bdll_pkg::K_DEL_TAIL, 0, 0);
    queue_req(bdll_pkg::K_LENGTH, 0, 0);
    queue_raw(4'hf, 8'hff, 32'hffff_ffff);
    queue_raw(4'ha, 8'h00, 32'h0);
    queue_req(bdll_pkg::K_DEL_HEAD, 0, 0);
    // fill to full, check full, then drain
    for (int i = 0; i < LIST_DEPTH + 1; i++) queue_req(bdll_pkg::K_INS_TAIL, 0, $urandom());
    queue_req(bdll_pkg::K_INS_POS, 100, 1);
    queue_req(bdll_pkg::K_INS_POS, 255, 1);
    queue_req(bdll_pkg::K_LENGTH, 0, 0);
    queue_req(bdll_pkg::K_DEL_POS, 255, 0);
    for (int i = 0; i < LIST_DEPTH; i++) queue_req(bdll_pkg::K_DEL_HEAD, 0, 0);
    queue_random(600, 45);
    wait_drained();

    sender_idle_pct = 62;
    queue_random(400, 40);
    wait_drained();

    sender_idle_pct = 0;
    queue_random(150, 60);
    wait_drained();

    repeat (600) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
